>>> hw/rtl/pdhc_pkg.sv
// Pump duty hysteresis controller package: register indexes, limits,
// duty steps and the structs passed between the block's modules.
// No dependencies.
package pdhc_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // Effective target range, 1/16 degree
  localparam logic [9:0] TargetLo = 10'd448;
  localparam logic [9:0] TargetHi = 10'd608;

  // Error thresholds above target, 1/16 degree
  localparam logic signed [12:0] ErrStep3 = 13'sd48;
  localparam logic signed [12:0] ErrStep2 = 13'sd32;
  localparam logic signed [12:0] ErrStep1 = 13'sd16;

  localparam logic [7:0] DutyStep3 = 8'd255;
  localparam logic [7:0] DutyStep2 = 8'd200;
  localparam logic [7:0] DutyStep1 = 8'd160;
  localparam logic [7:0] DutyStep0 = 8'd120;

  typedef enum logic [CfgIndexW-1:0] {
    REG_TARGET_TEMP   = 3'd0,
    REG_HYST_BAND     = 3'd1,
    REG_SKIN_MAX      = 3'd2,
    REG_SKIN_MIN      = 3'd3,
    REG_MIN_RUN_DUTY  = 3'd4,
    REG_RAMP_STEP     = 3'd5,
    REG_KICK_DURATION = 3'd6,
    REG_KICK_DUTY     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]         target_temp;
    logic [7:0]         hysteresis_band;
    logic signed [11:0] skin_max;
    logic signed [11:0] skin_min;
    logic [7:0]         min_run_duty;
    logic [7:0]         ramp_step;
    logic [15:0]        kick_duration_ms;
    logic [7:0]         kick_duty;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  current_duty;
    logic        pump_was_on;
    logic [31:0] pump_start_time;
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] ramped_duty;
    logic       drive_write;
    logic [7:0] drive_duty;
    logic       safety_trip;
  } ctl_result_t;

endpackage

>>> hw/rtl/pdhc_if.sv
// Request channel interfaces of the pump duty controller: sample in,
// result out. Depends on nothing.
interface pdhc_in_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temperature;
  logic               temp_valid;
  logic [31:0]        time_ms;

  modport source (output valid, output temperature, output temp_valid,
                  output time_ms, input ready);
  modport sink (input valid, input temperature, input temp_valid,
                input time_ms, output ready);
endinterface

interface pdhc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ramped_duty;
  logic       drive_write;
  logic [7:0] drive_duty;
  logic       safety_trip;

  modport source (output valid, output ramped_duty, output drive_write,
                  output drive_duty, output safety_trip, input ready);
  modport sink (input valid, input ramped_duty, input drive_write,
                input drive_duty, input safety_trip, output ready);
endinterface

>>> hw/rtl/pdhc_cfg_regs.sv
// Configuration register file of the pump duty controller.
// Depends on pdhc_pkg.
module pdhc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pdhc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pdhc_pkg::CfgDataW-1:0]  cfg_data,
  output pdhc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp      <= 10'd544;
      cfg.hysteresis_band  <= 8'd8;
      cfg.skin_max         <= 12'sd640;
      cfg.skin_min         <= 12'sd288;
      cfg.min_run_duty     <= 8'd70;
      cfg.ramp_step        <= 8'd5;
      cfg.kick_duration_ms <= 16'd300;
      cfg.kick_duty        <= 8'd255;
    end else if (cfg_we) begin
      unique case (pdhc_pkg::cfg_reg_t'(cfg_index))
        pdhc_pkg::REG_TARGET_TEMP:   cfg.target_temp      <= cfg_data[9:0];
        pdhc_pkg::REG_HYST_BAND:     cfg.hysteresis_band  <= cfg_data[7:0];
        pdhc_pkg::REG_SKIN_MAX:      cfg.skin_max         <= signed'(cfg_data[11:0]);
        pdhc_pkg::REG_SKIN_MIN:      cfg.skin_min         <= signed'(cfg_data[11:0]);
        pdhc_pkg::REG_MIN_RUN_DUTY:  cfg.min_run_duty     <= cfg_data[7:0];
        pdhc_pkg::REG_RAMP_STEP:     cfg.ramp_step        <= cfg_data[7:0];
        pdhc_pkg::REG_KICK_DURATION: cfg.kick_duration_ms <= cfg_data[15:0];
        pdhc_pkg::REG_KICK_DUTY:     cfg.kick_duty        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/pdhc_core.sv
// Per-tick control logic: safety check, hysteresis request, slew limit,
// minimum run and kick window. Purely combinational. Depends on pdhc_pkg.
module pdhc_core (
  input  pdhc_pkg::cfg_t        cfg,
  input  pdhc_pkg::ctl_state_t  state,
  input  logic signed [11:0]    temperature,
  input  logic                  temp_valid,
  input  logic [31:0]           time_ms,
  output pdhc_pkg::ctl_result_t res,
  output pdhc_pkg::ctl_state_t  state_next
);

  logic [9:0]         tgt;
  logic signed [12:0] err;
  logic signed [12:0] band_s;
  logic               trip;
  logic [7:0]         req;
  logic [8:0]         up_sum;
  logic signed [9:0]  dn_diff;
  logic [7:0]         cur_next;
  logic [7:0]         drv;
  logic               on;
  logic               start;
  logic [31:0]        start_time;
  logic [31:0]        elapsed;

  always_comb begin
    priority if (cfg.target_temp < pdhc_pkg::TargetLo) tgt = pdhc_pkg::TargetLo;
    else if (cfg.target_temp > pdhc_pkg::TargetHi)     tgt = pdhc_pkg::TargetHi;
    else                                               tgt = cfg.target_temp;

    trip   = !temp_valid || (temperature >= cfg.skin_max)
             || (temperature <= cfg.skin_min);
    err    = {temperature[11], temperature} - signed'({3'b000, tgt});
    band_s = signed'({5'b00000, cfg.hysteresis_band});

    priority if (trip)                          req = 8'd0;
    else if (err <= band_s && err >= -band_s)   req = state.current_duty;
    else if (err > band_s) begin
      priority if (err > pdhc_pkg::ErrStep3)      req = pdhc_pkg::DutyStep3;
      else if (err > pdhc_pkg::ErrStep2)          req = pdhc_pkg::DutyStep2;
      else if (err > pdhc_pkg::ErrStep1)          req = pdhc_pkg::DutyStep1;
      else                                        req = pdhc_pkg::DutyStep0;
    end
    else if (state.current_duty <= cfg.min_run_duty) req = 8'd0;
    else                                        req = cfg.min_run_duty;

    // slew limit
    up_sum  = {1'b0, state.current_duty} + {1'b0, cfg.ramp_step};
    dn_diff = signed'({2'b00, state.current_duty}) - signed'({2'b00, cfg.ramp_step});
    priority if (req > state.current_duty)
      cur_next = (up_sum > {1'b0, req}) ? req : up_sum[7:0];
    else if (req < state.current_duty)
      cur_next = (dn_diff < signed'({2'b00, req})) ? req : dn_diff[7:0];
    else
      cur_next = state.current_duty;

    // drive stage
    if (cur_next == 8'd0)                drv = 8'd0;
    else if (cur_next < cfg.min_run_duty) drv = cfg.min_run_duty;
    else                                 drv = cur_next;
    on         = cur_next != 8'd0;
    start      = on && !state.pump_was_on;
    start_time = start ? time_ms : state.pump_start_time;
    elapsed    = time_ms - start_time;

    res.ramped_duty = cur_next;
    res.safety_trip = trip;
    priority if (on && elapsed >= {16'd0, cfg.kick_duration_ms}) begin
      res.drive_write = 1'b1;
      res.drive_duty  = drv;
    end else if (!on) begin
      res.drive_write = 1'b1;
      res.drive_duty  = 8'd0;
    end else if (start) begin
      res.drive_write = 1'b1;
      res.drive_duty  = cfg.kick_duty;
    end else begin
      res.drive_write = 1'b0;
      res.drive_duty  = 8'd0;
    end

    state_next.current_duty    = cur_next;
    state_next.pump_was_on     = on;
    state_next.pump_start_time = start_time;
  end

endmodule

>>> hw/rtl/pump_duty_hysteresis_controller.sv
// Pump duty hysteresis controller, top level: one result request for every
// sample request, one sample per clock sustained while the sink takes results.
// A sample is registered in the input register on acceptance and its result
// then in the output register, which holds it while the sink stalls; the
// input register keeps taking samples until both registers are full.
// The loop through current duty, pump state and start time closes within the
// single compute stage, so consecutive samples see each other's state.
// Depends on pdhc_pkg, pdhc_if, pdhc_cfg_regs and pdhc_core.
module pump_duty_hysteresis_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pdhc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pdhc_pkg::CfgDataW-1:0]  cfg_data,
  pdhc_in_if.sink                        sample,
  pdhc_out_if.source                     result
);

  pdhc_pkg::cfg_t        cfg;
  pdhc_pkg::ctl_state_t  state;
  pdhc_pkg::ctl_state_t  state_next;
  pdhc_pkg::ctl_result_t core_res;
  pdhc_pkg::ctl_result_t res_q;

  logic               s1_valid;
  logic signed [11:0] s1_temperature;
  logic               s1_temp_valid;
  logic [31:0]        s1_time_ms;
  logic               o_valid;
  logic               advance;
  logic               fire;

  pdhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdhc_core u_core (
    .cfg         (cfg),
    .state       (state),
    .temperature (s1_temperature),
    .temp_valid  (s1_temp_valid),
    .time_ms     (s1_time_ms),
    .res         (core_res),
    .state_next  (state_next)
  );

  assign advance      = !o_valid || result.ready;
  assign fire         = s1_valid && advance;
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_temperature <= sample.temperature;
      s1_temp_valid  <= sample.temp_valid;
      s1_time_ms     <= sample.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  assign result.valid       = o_valid;
  assign result.ramped_duty = res_q.ramped_duty;
  assign result.drive_write = res_q.drive_write;
  assign result.drive_duty  = res_q.drive_duty;
  assign result.safety_trip = res_q.safety_trip;

  // pump flag tracks nonzero duty
  a_was_on_tracks_duty: assert property (@(posedge clk) disable iff (rst)
    state.pump_was_on == (state.current_duty != 8'd0))
    else $error("pump_was_on out of step with current_duty");

  // no write means no duty
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && !res_q.drive_write |-> res_q.drive_duty == 8'd0)
    else $error("drive_duty nonzero without a write");

  // zero duty always writes the pump off
  a_zero_duty_off: assert property (@(posedge clk) disable iff (rst)
    o_valid && res_q.ramped_duty == 8'd0 |-> res_q.drive_write
      && res_q.drive_duty == 8'd0)
    else $error("zero duty did not switch the pump off");

  // state moves only when a result is produced
  a_state_on_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state))
    else $error("controller state changed without a sample");

endmodule
